/* hw/rtl/smbf_pkg.sv */
// Shared types, constants and the three-tap kernel of the separable 3x3 filter.
package smbf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COL_BITS    = 12;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [12:0] MIN_DIM    = 13'd3;
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    // floor(s / 3) == (s * MEAN_RECIP) >> MEAN_SHIFT, exact for s < 2**19
    localparam logic [17:0] MEAN_RECIP = 18'd174763;
    localparam int          MEAN_SHIFT = 19;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FILTER_MODE  = 2'd2;

    localparam logic [1:0] MODE_MAX = 2'd0;
    localparam logic [1:0] MODE_MIN = 2'd1;

    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [SAMPLE_BITS-1:0] pixel_value;
    } pix_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] filtered_value;
        logic                   frame_last;
    } res_t;

    typedef struct packed {
        logic [10:0] image_width;
        logic [12:0] image_height;
        logic [1:0]  filter_mode;
    } cfg_t;

    // One queue entry: a drain request, or a pixel request carrying one or two
    // vertical jobs (the second one only at the end of a row).
    typedef struct packed {
        logic                   drain;
        logic                   two;
        logic                   bank;
        logic                   row_zero;
        logic                   row_one;
        logic                   last;
        logic [COL_BITS-1:0]    col;
        logic [SAMPLE_BITS-1:0] a;
        logic [SAMPLE_BITS-1:0] b;
        logic [SAMPLE_BITS-1:0] c;
    } op_t;

    function automatic logic [SAMPLE_BITS-1:0] tap3(
        input logic [1:0]             mode,
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [SAMPLE_BITS-1:0] c
    );
        logic [SAMPLE_BITS-1:0] m;
        logic [17:0]            s;
        logic [35:0]            prod;
        logic [SAMPLE_BITS-1:0] r;
        begin
            s    = {2'b00, a} + {2'b00, b} + {2'b00, c};
            prod = {18'd0, s} * {18'd0, MEAN_RECIP};
            unique case (mode)
                MODE_MAX:
                begin
                    m = (a > b) ? a : b;
                    r = (m > c) ? m : c;
                end
                MODE_MIN:
                begin
                    m = (a < b) ? a : b;
                    r = (m < c) ? m : c;
                end
                default:
                begin
                    m = a;
                    r = prod[MEAN_SHIFT +: SAMPLE_BITS];
                end
            endcase
            tap3 = r;
        end
    endfunction

endpackage

/* hw/rtl/separable_3x3_morph_box_filter.sv */
// Top level of the separable 3x3 dilate / erode / box filter.
//
// Streams a one-channel image in raster order, one pixel request per unstalled clock,
// and returns the 3x3 maximum, minimum or floor-mean with repeated borders.
// Output lags the input by one row: a pixel at column x of row y (x, y >= 1)
// releases the result for column x-1 of row y-1, and the last pixel of a row
// also releases that row's last column, so a row-end pixel yields two results.
// Row 0 and column 0 yield nothing. After the last pixel of a frame send one
// drain request per column; each returns one pixel of the final row, and
// frame_last marks the very last one. Pixels sent while draining, and drain
// requests sent outside a drain, are dropped without a result.
// Rate: one request per clock sustained while res_stall is low; the back end
// retires one result per unstalled clock, so the queue absorbs the extra result
// at each row end. A request is written to the queue at the accepting edge,
// then passes the line-store read, the horizontal tap and the vertical tap
// into the result register, each step registered; the second result of a
// row-end pixel follows the first. The line stores are two banks of
// MAX_WIDTH x 16 bits, each read once and written once per clock; they need
// no clearing after reset. Configuration writes are always taken (cfg_ready
// is tied high) and must only be issued while the block is idle.
module separable_3x3_morph_box_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    // pixel / drain requests
    input  logic           pix_valid,
    output logic           pix_stall,
    input  smbf_pkg::pix_t pix,
    // results
    output logic           res_valid,
    input  logic           res_stall,
    output smbf_pkg::res_t res,
    // register writes
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [12:0]    cfg_data
);
    import smbf_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic q_full, q_push, q_pop, q_head_valid;
    op_t  q_entry, q_head;

    assign cfg_ready = 1'b1;

    // register file; unknown indexes are swallowed
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[10:0];
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data;
                CFG_FILTER_MODE:  cfg_next.filter_mode  = cfg_data[1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 11'd640;
            cfg_reg.image_height <= 13'd480;
            cfg_reg.filter_mode  <= MODE_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // position tracking and horizontal taps gathered per request
    smbf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pix_valid (pix_valid),
        .pix       (pix),
        .pix_stall (pix_stall),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // decouples input stalls from output stalls
    smbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // horizontal result, line stores, vertical result
    smbf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (cfg_reg.filter_mode),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

/* hw/rtl/smbf_front.sv */
// Front end: accepts pixel and drain requests, tracks position, builds queue entries.
module smbf_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  smbf_pkg::cfg_t cfg,
    input  logic          pix_valid,
    input  smbf_pkg::pix_t pix,
    output logic          pix_stall,
    input  logic          q_full,
    output logic          q_push,
    output smbf_pkg::op_t q_entry
);
    import smbf_pkg::*;

    localparam int          CW       = $clog2(MAX_WIDTH);
    localparam logic [12:0] MAX_W13  = 13'(MAX_WIDTH);

    logic [CW-1:0]          col_reg, col_next;
    logic [11:0]            row_reg, row_next;
    logic [CW-1:0]          drain_col_reg, drain_col_next;
    logic                   draining_reg, draining_next;
    logic [SAMPLE_BITS-1:0] rw0_reg, rw0_next;
    logic [SAMPLE_BITS-1:0] rw1_reg, rw1_next;

    logic [12:0]   w_ext, w_eff, h_ext, h_eff;
    logic [CW-1:0] w_last;
    logic [11:0]   h_last;
    logic          accept, row_end, drain_last;

    assign pix_stall = q_full;
    assign accept    = pix_valid && !q_full;

    // width and height saturated into their legal ranges
    always_comb
    begin
        w_ext = {2'b00, cfg.image_width};
        h_ext = cfg.image_height;
        if (w_ext < MIN_DIM)
            w_eff = MIN_DIM;
        else if (w_ext > MAX_W13)
            w_eff = MAX_W13;
        else
            w_eff = w_ext;
        if (h_ext < MIN_DIM)
            h_eff = MIN_DIM;
        else if (h_ext > MAX_HEIGHT)
            h_eff = MAX_HEIGHT;
        else
            h_eff = h_ext;
        w_last = CW'(w_eff - 13'd1);
        h_last = 12'(h_eff - 13'd1);
    end

    assign row_end    = (col_reg >= w_last);
    assign drain_last = (drain_col_reg >= w_last);

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        drain_col_next = drain_col_reg;
        draining_next  = draining_reg;
        rw0_next       = rw0_reg;
        rw1_next       = rw1_reg;
        q_push         = 1'b0;
        q_entry        = '0;
        q_entry.bank   = row_reg[0];
        if (accept)
        begin
            if (pix.func == FUNC_DRAIN)
            begin
                if (draining_reg)
                begin
                    q_push        = 1'b1;
                    q_entry.drain = 1'b1;
                    q_entry.col   = COL_BITS'(drain_col_reg);
                    q_entry.last  = drain_last;
                    if (drain_last)
                    begin
                        draining_next  = 1'b0;
                        drain_col_next = '0;
                        col_next       = '0;
                        row_next       = '0;
                    end
                    else
                    begin
                        drain_col_next = drain_col_reg + CW'(1);
                    end
                end
            end
            else if (!draining_reg)
            begin
                rw1_next = pix.pixel_value;
                if (col_reg != '0)
                begin
                    q_push           = 1'b1;
                    q_entry.two      = row_end;
                    q_entry.row_zero = (row_reg == 12'd0);
                    q_entry.row_one  = (row_reg == 12'd1);
                    q_entry.col      = COL_BITS'(col_reg - CW'(1));
                    q_entry.a        = rw1_reg;
                    q_entry.b        = (col_reg == CW'(1)) ? rw1_reg : rw0_reg;
                    q_entry.c        = pix.pixel_value;
                    rw0_next         = rw1_reg;
                end
                if (row_end)
                begin
                    col_next = '0;
                    if (row_reg >= h_last)
                    begin
                        draining_next  = 1'b1;
                        drain_col_next = '0;
                    end
                    else
                    begin
                        row_next = row_reg + 12'd1;
                    end
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            drain_col_reg <= '0;
            draining_reg  <= 1'b0;
            rw0_reg       <= '0;
            rw1_reg       <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            drain_col_reg <= drain_col_next;
            draining_reg  <= draining_next;
            rw0_reg       <= rw0_next;
            rw1_reg       <= rw1_next;
        end
    end

endmodule

/* hw/rtl/smbf_queue.sv */
// Short request queue between the front end and the back end.
module smbf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  smbf_pkg::op_t push_entry,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output smbf_pkg::op_t head
);
    import smbf_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    op_t             entries_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* hw/rtl/smbf_back.sv */
// Back end: horizontal tap, line-store read/write, vertical tap, result register.
module smbf_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     mode,
    input  logic           head_valid,
    input  smbf_pkg::op_t  head,
    output logic           pop,
    output logic           res_valid,
    input  logic           res_stall,
    output smbf_pkg::res_t res
);
    import smbf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic                   drain;
        logic                   bank;
        logic                   row_zero;
        logic                   row_one;
        logic                   last;
        logic [CW-1:0]          col;
        logic [SAMPLE_BITS-1:0] ha;
        logic [SAMPLE_BITS-1:0] hb;
        logic [SAMPLE_BITS-1:0] hc;
    } s1_t;

    typedef struct packed {
        logic                   drain;
        logic                   bank;
        logic                   row_zero;
        logic                   row_one;
        logic                   last;
        logic [CW-1:0]          col;
        logic [SAMPLE_BITS-1:0] hv;
        logic [SAMPLE_BITS-1:0] prv;
        logic [SAMPLE_BITS-1:0] cur;
    } s2_t;

    // line stores, one per row parity
    logic [SAMPLE_BITS-1:0] bank0_mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] bank1_mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] rd0_reg, rd1_reg;

    logic second_reg, second_next;
    logic s1_valid_reg, s2_valid_reg, res_valid_reg;
    logic s1_valid_next, s2_valid_next, res_valid_next;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    res_t res_reg, res_next;

    logic                   issue, s1_go, s2_go, s2_emits, out_free, mem_we;
    logic [SAMPLE_BITS-1:0] va, vb, vc;

    assign out_free = !res_valid_reg || !res_stall;
    assign s2_emits = s2_reg.drain || !s2_reg.row_zero;
    assign s2_go    = s2_valid_reg && (!s2_emits || out_free);
    assign s1_go    = s1_valid_reg && (!s2_valid_reg || s2_go);
    assign issue    = head_valid && (!s1_valid_reg || s1_go);
    assign pop      = issue && (!head.two || second_reg);
    assign mem_we   = s2_go && !s2_reg.drain;

    always_comb
    begin
        // issue: the second job of a row-end pixel is tap3(prev, p, p) one column on
        s1_next          = s1_reg;
        s1_next.drain    = head.drain;
        s1_next.bank     = head.bank;
        s1_next.row_zero = head.row_zero;
        s1_next.row_one  = head.row_one;
        s1_next.last     = head.last;
        s1_next.col      = second_reg ? head.col[CW-1:0] + CW'(1) : head.col[CW-1:0];
        s1_next.ha       = head.a;
        s1_next.hb       = second_reg ? head.c : head.b;
        s1_next.hc       = head.c;
        second_next      = issue ? (head.two && !second_reg) : second_reg;
        s1_valid_next    = issue || (s1_valid_reg && !s1_go);

        s2_next          = s2_reg;
        s2_next.drain    = s1_reg.drain;
        s2_next.bank     = s1_reg.bank;
        s2_next.row_zero = s1_reg.row_zero;
        s2_next.row_one  = s1_reg.row_one;
        s2_next.last     = s1_reg.last;
        s2_next.col      = s1_reg.col;
        s2_next.hv       = tap3(mode, s1_reg.ha, s1_reg.hb, s1_reg.hc);
        s2_next.prv      = s1_reg.bank ? rd0_reg : rd1_reg;
        s2_next.cur      = s1_reg.bank ? rd1_reg : rd0_reg;
        s2_valid_next    = s1_go || (s2_valid_reg && !s2_go);

        va = s2_reg.prv;
        if (s2_reg.drain)
        begin
            vb = s2_reg.cur;
            vc = s2_reg.cur;
        end
        else
        begin
            vb = s2_reg.row_one ? s2_reg.prv : s2_reg.cur;
            vc = s2_reg.hv;
        end
        res_next.filtered_value = tap3(mode, va, vb, vc);
        res_next.frame_last     = s2_reg.drain && s2_reg.last;
        res_valid_next          = (s2_go && s2_emits) || (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            second_reg    <= second_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_reg  <= s1_next;
            rd0_reg <= bank0_mem[s1_next.col];
            rd1_reg <= bank1_mem[s1_next.col];
        end
        if (s1_go)
            s2_reg <= s2_next;
        if (s2_go && s2_emits)
            res_reg <= res_next;
        if (mem_we && !s2_reg.bank)
            bank0_mem[s2_reg.col] <= s2_reg.hv;
        if (mem_we && s2_reg.bank)
            bank1_mem[s2_reg.col] <= s2_reg.hv;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
